>>> hw/rtl/upc_pkg.sv
// Shared types, constants and byte classifiers for the percent codec.
// No dependencies; used by every module of the block.
package upc_pkg;

    localparam logic [7:0] PCT_CHAR = 8'h25;
    localparam logic [8*16-1:0] HEX_CHARS = "0123456789ABCDEF";
    localparam logic [3:0] NIBBLE_MASK = 4'hF;
    localparam int ENTRY_BYTES = 3;

    typedef enum logic {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } mode_t;

    typedef enum logic [0:0] {
        REG_MODE = 1'b0
    } reg_index_t;

    // One converted item: up to three bytes, first byte in slot 0
    typedef struct packed {
        logic [ENTRY_BYTES-1:0][7:0] bytes;
        logic [1:0]                  count;
        logic                        last;
    } upc_entry_t;

    typedef struct packed {
        logic full;
        logic valid;
    } upc_qstat_t;

    function automatic logic keeps_literal(input logic [7:0] c);
        logic keep;
        case (c) inside
            [8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]: keep = 1'b1;
            8'h2D, 8'h2E, 8'h5F, 8'h7E, 8'h2F, 8'h3A, 8'h40,
            8'h21, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A,
            8'h2B, 8'h2C, 8'h3B, 8'h3D:                  keep = 1'b1;
            default:                                     keep = 1'b0;
        endcase
        return keep;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        logic hex;
        case (c) inside
            [8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]: hex = 1'b1;
            default:                                     hex = 1'b0;
        endcase
        return hex;
    endfunction

    // Value of a hex digit; letters of either case share the low nibble rule
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        case (c) inside
            [8'h30:8'h39]: v = c[3:0];
            [8'h61:8'h66],
            [8'h41:8'h46]: v = c[3:0] + 4'd9;
            default:       v = 4'd0;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [3:0] pos;
        pos = NIBBLE_MASK - n;
        return HEX_CHARS[{pos, 3'b000} +: 8];
    endfunction

endpackage

>>> hw/rtl/upc_front.sv
// Front end: accepts input bytes, tracks the pending escape and builds one
// queue entry of up to three output bytes per item. Uses upc_pkg.
module upc_front
    import upc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       mode,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       push,
    output upc_entry_t entry,
    output logic       pend_idle
);

    typedef enum logic [1:0] {
        PEND_NONE  = 2'd0,
        PEND_PCT   = 2'd1,
        PEND_DIGIT = 2'd2
    } pend_t;

    pend_t      pend_reg, pend_next;
    logic [7:0] held_reg, held_next;

    logic       fresh_hold;
    logic [1:0] fresh_cnt;
    pend_t      fresh_pend;

    // Byte seen with no escape pending
    always_comb
    begin
        if (in_byte == PCT_CHAR && !in_last)
        begin
            fresh_hold = 1'b1;
            fresh_cnt  = 2'd0;
            fresh_pend = PEND_PCT;
        end
        else
        begin
            fresh_hold = 1'b0;
            fresh_cnt  = 2'd1;
            fresh_pend = PEND_NONE;
        end
    end

    always_comb
    begin
        entry.bytes = '{default: 8'h00};
        entry.count = 2'd0;
        entry.last  = in_last;
        pend_next   = pend_reg;
        held_next   = held_reg;
        if (mode_t'(mode) == MODE_ENCODE)
        begin
            pend_next = PEND_NONE;
            held_next = 8'h00;
            if (keeps_literal(in_byte))
            begin
                entry.bytes[0] = in_byte;
                entry.count    = 2'd1;
            end
            else
            begin
                entry.bytes[0] = PCT_CHAR;
                entry.bytes[1] = hex_char(in_byte[7:4]);
                entry.bytes[2] = hex_char(in_byte[3:0]);
                entry.count    = 2'd3;
            end
        end
        else
        begin
            case (pend_reg)
                PEND_PCT:
                begin
                    if (is_hex(in_byte) && !in_last)
                    begin
                        pend_next = PEND_DIGIT;
                        held_next = in_byte;
                    end
                    else
                    begin
                        entry.bytes[0] = PCT_CHAR;
                        entry.bytes[1] = in_byte;
                        entry.count    = 2'd1 + fresh_cnt;
                        pend_next      = fresh_pend;
                    end
                end
                PEND_DIGIT:
                begin
                    if (is_hex(in_byte))
                    begin
                        entry.bytes[0] = {hex_value(held_reg), hex_value(in_byte)};
                        entry.count    = 2'd1;
                        pend_next      = PEND_NONE;
                    end
                    else
                    begin
                        // malformed: send the escape as is, then rescan this byte
                        entry.bytes[0] = PCT_CHAR;
                        entry.bytes[1] = held_reg;
                        entry.bytes[2] = in_byte;
                        entry.count    = 2'd2 + fresh_cnt;
                        pend_next      = fresh_pend;
                    end
                end
                default:
                begin
                    entry.bytes[0] = in_byte;
                    entry.count    = fresh_cnt;
                    pend_next      = fresh_hold ? PEND_PCT : PEND_NONE;
                end
            endcase
        end
        if (in_last)
        begin
            pend_next = PEND_NONE;
            held_next = 8'h00;
        end
    end

    assign push      = accept && (entry.count != 2'd0);
    assign pend_idle = (pend_reg == PEND_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= PEND_NONE;
            held_reg <= 8'h00;
        end
        else if (accept)
        begin
            pend_reg <= pend_next;
            held_reg <= held_next;
        end
    end

endmodule

>>> hw/rtl/upc_queue.sv
// Short entry queue between front and back end; register array, one write
// and one read per cycle. Uses upc_pkg.
module upc_queue
    import upc_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  upc_entry_t push_entry,
    input  logic       pop,
    output upc_entry_t head,
    output upc_qstat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);

    upc_entry_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] level_reg, level_next;
    logic do_push, do_pop;

    assign stat.full  = (level_reg == LVL_W'(DEPTH));
    assign stat.valid = (level_reg != '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && stat.valid;
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            level_next = level_reg + 1'b1;
        else if (do_pop && !do_push)
            level_next = level_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

>>> hw/rtl/upc_back.sv
// Back end: drains the head queue entry one byte per cycle, while out_stall
// is low, into the output register. Uses upc_pkg.
module upc_back
    import upc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  upc_entry_t head,
    input  upc_qstat_t qstat,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       out_last
);

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic       load;
    logic       at_end;
    logic [7:0] sel_byte;

    assign load   = !valid_reg || !out_stall;
    assign at_end = (idx_reg == (head.count - 2'd1));

    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_byte = head.bytes[0];
            2'd1:    sel_byte = head.bytes[1];
            2'd2:    sel_byte = head.bytes[2];
            default: sel_byte = head.bytes[0];
        endcase
    end

    always_comb
    begin
        pop        = 1'b0;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = qstat.valid;
            if (qstat.valid)
            begin
                byte_next = sel_byte;
                last_next = head.last && at_end;
                if (at_end)
                begin
                    pop      = 1'b1;
                    idx_next = 2'd0;
                end
                else
                    idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;

endmodule

>>> hw/rtl/uri_percent_codec.sv
// Top level of the percent encoder/decoder: APB mode register, front end,
// entry queue and back end. Depends on upc_pkg, upc_front, upc_queue, upc_back.
//
//  Channel  Handshake              Payload
//  input    in_valid / in_stall    in_byte[7:0], in_last
//  output   out_valid / out_stall  out_byte[7:0], out_last
//  config   APB psel/penable       paddr[2:0], pwdata/prdata[31:0] (mode at 0x0)
//
// One input item is taken per cycle while the queue has room; each yields
// zero to three output bytes. The back end sends one byte per cycle while
// out_stall is low, so sustained throughput follows the output byte count.
// in_stall rises only when all QUEUE_DEPTH entries are occupied.
// Reset clears the mode (encode), the pending escape, the queue and the output.
module uri_percent_codec
    import upc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        out_last
);

    logic       mode_reg, mode_next;
    logic       cfg_wr;
    reg_index_t reg_idx;
    logic       accept;
    logic       push;
    logic       pop;
    logic       pend_idle;
    upc_entry_t push_entry;
    upc_entry_t head;
    upc_qstat_t qstat;

    assign pready  = 1'b1;
    assign reg_idx = reg_index_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign prdata  = (reg_idx == REG_MODE) ? {31'd0, mode_reg} : 32'd0;

    always_comb
    begin
        mode_next = mode_reg;
        if (cfg_wr && reg_idx == REG_MODE)
            mode_next = pwdata[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_ENCODE;
        else
            mode_reg <= mode_next;
    end

    assign in_stall = qstat.full;
    assign accept   = in_valid && !in_stall;

    upc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (mode_reg),
        .accept    (accept),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .push      (push),
        .entry     (push_entry),
        .pend_idle (pend_idle)
    );

    upc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .stat       (qstat)
    );

    upc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .qstat     (qstat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

    // A string end always leaves no escape pending
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_last |=> pend_idle)
        else $error("escape still pending after last byte");

    // Encoding a reserved byte always queues a three-byte escape
    a_encode_escape: assert property (@(posedge clk) disable iff (!rst_n)
        accept && mode_reg == MODE_ENCODE && !keeps_literal(in_byte)
            |-> push && push_entry.count == 2'd3)
        else $error("encoded escape not queued as three bytes");

    // The back end never pops an empty queue
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> qstat.valid)
        else $error("pop from empty queue");

    // A queued entry never carries zero bytes
    a_entry_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.valid |-> head.count != 2'd0)
        else $error("empty entry at queue head");

endmodule
